>>> hdl/float32_to_pcm16_saturating_defines.svh
// Assertion macros used by the float-to-PCM converter top level.
// No dependencies.
`ifndef FLOAT32_TO_PCM16_SATURATING_DEFINES_SVH
`define FLOAT32_TO_PCM16_SATURATING_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define F2P_ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("implication failed");

// Check that a condition implies another in the next cycle.
`define F2P_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle implication failed");

`endif

>>> hdl/f2p_pkg.sv
// Types and constants for the float-to-PCM converter.
// No dependencies.
package f2p_pkg;
	localparam int unsigned ScaleFactor = 32767;
	localparam logic [7:0] ExpSpecial = 8'hFF;
	localparam logic [16:0] MagSat = 17'd65535;
	localparam logic [16:0] MagMaxPos = 17'd32767;
	localparam logic [16:0] MagMaxNeg = 17'd32768;

	typedef struct packed {
		logic [31:0] float_sample;
		logic        buffer_end;
	} f2p_in_t;

	typedef struct packed {
		logic signed [15:0] pcm_sample;
		logic               buffer_end_out;
	} f2p_out_t;

	// Product class decided in stage 1 and refined in stage 3.
	typedef enum logic [1:0] {
		CLS_NORMAL,
		CLS_ZERO,
		CLS_SAT
	} f2p_cls_t;
endpackage

>>> hdl/f2p_if.sv
// Valid/ready channel interface for the converter.
// No dependencies.
interface f2p_if #(
	parameter int unsigned W = 1
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/float32_to_pcm16_saturating.sv
// Top level of the float32 to 16-bit PCM converter.
// Depends on f2p_pkg, f2p_if, f2p_mul, f2p_round and the defines header.
//
// Converts one single-precision sample per clock into saturated 16-bit PCM
// (scale by 32767, round to float, round half away, NaN to zero) through a
// four-stage pipeline (unpack, multiply, round to 24 bits, scale and saturate);
// the whole pipeline advances whenever the output register is empty or being
// taken, so throughput is one beat per cycle while the output is not stalled.
`include "float32_to_pcm16_saturating_defines.svh"
module float32_to_pcm16_saturating import f2p_pkg::*; (
	input logic clk,
	input logic arst_n,
	f2p_if.sink   in_ch,
	f2p_if.source out_ch
);
	logic        en;
	logic        v2;
	logic [38:0] prod;
	logic [7:0]  ex;
	f2p_cls_t    cls;
	logic        neg;
	logic        bend;
	f2p_in_t     in_item;
	f2p_out_t    out_item;

	// Advance when the output slot is free or being drained
	assign en           = !out_ch.valid || out_ch.ready;
	assign in_ch.ready  = en;
	assign in_item      = in_ch.data;
	assign out_ch.data  = out_item;

	f2p_mul u_mul (
		.clk, .arst_n, .en,
		.in_valid(in_ch.valid), .in_item,
		.out_valid(v2), .prod_s2(prod), .exp_s2(ex), .cls_s2(cls),
		.neg_s2(neg), .end_s2(bend)
	);

	f2p_round u_round (
		.clk, .arst_n, .en,
		.in_valid(v2), .prod, .exp_in(ex), .cls, .neg, .end_in(bend),
		.out_valid(out_ch.valid), .out_item
	);

	`F2P_ASSERT_NEXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
	`F2P_ASSERT_IMPL(a_ready, clk, arst_n, !out_ch.valid, in_ch.ready)
	`F2P_ASSERT_NEXT(a_stall, clk, arst_n, !en, $stable(prod))
endmodule

>>> hdl/f2p_mul.sv
// Stages 1 and 2: classify the sample and form the 39-bit significand product.
// Depends on f2p_pkg.
module f2p_mul import f2p_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  f2p_in_t     in_item,
	output logic        out_valid,
	output logic [38:0] prod_s2,
	output logic [7:0]  exp_s2,
	output f2p_cls_t    cls_s2,
	output logic        neg_s2,
	output logic        end_s2
);
	logic        valid_s1;
	logic [23:0] sig_s1;
	logic [7:0]  exp_s1;
	f2p_cls_t    cls_s1;
	logic        neg_s1;
	logic        end_s1;
	f2p_cls_t    cls_d;
	logic [7:0]  e_d;
	logic [22:0] f_d;

	// Classify special encodings
	always_comb begin
		e_d = in_item.float_sample[30:23];
		f_d = in_item.float_sample[22:0];
		if (e_d == ExpSpecial) begin
			cls_d = (f_d != 23'd0) ? CLS_ZERO : CLS_SAT;
		end else if (e_d == 8'd0) begin
			cls_d = CLS_ZERO;
		end else begin
			cls_d = CLS_NORMAL;
		end
	end

	// Valid bits advance while enabled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= in_valid;
			out_valid <= valid_s1;
		end
	end

	// Stage payload: unpack, then multiply
	always_ff @(posedge clk) begin
		if (en) begin
			sig_s1  <= {1'b1, in_item.float_sample[22:0]};
			exp_s1  <= in_item.float_sample[30:23];
			cls_s1  <= cls_d;
			neg_s1  <= in_item.float_sample[31];
			end_s1  <= in_item.buffer_end;
			prod_s2 <= 39'(sig_s1) * 39'(ScaleFactor);
			exp_s2  <= exp_s1;
			cls_s2  <= cls_s1;
			neg_s2  <= neg_s1;
			end_s2  <= end_s1;
		end
	end
endmodule

>>> hdl/f2p_round.sv
// Stages 3 and 4: round product to 24 bits, then scale to an integer and saturate.
// Depends on f2p_pkg.
module f2p_round import f2p_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [38:0] prod,
	input  logic [7:0]  exp_in,
	input  f2p_cls_t    cls,
	input  logic        neg,
	input  logic        end_in,
	output logic        out_valid,
	output f2p_out_t    out_item
);
	// product of 24-bit sig and 15-bit constant has 38 or 39 bits
	logic        valid_s3;
	logic [24:0] r_s3;
	logic [5:0]  k_s3;
	f2p_cls_t    cls_s3;
	logic        neg_s3;
	logic        end_s3;
	logic        top;
	logic [23:0] r_t;
	logic [14:0] low;
	logic [14:0] half;
	logic        up;
	logic [24:0] r_d;
	logic signed [10:0] ex_d;
	logic [16:0] mag;
	logic [65:0] wide;
	logic [65:0] sum;
	logic [16:0] cap;

	// Round to nearest even at 24 significant bits
	always_comb begin
		top  = prod[38];
		r_t  = top ? prod[38:15] : prod[37:14];
		low  = top ? prod[14:0] : {1'b0, prod[13:0]};
		half = top ? 15'h4000 : 15'h2000;
		up   = (low > half) || ((low == half) && r_t[0]);
		r_d  = {1'b0, r_t} + 25'(up);
		// ex = e - 150 + sh; sh is 15 or 14
		ex_d = $signed({3'b0, exp_in}) - 11'sd150 + (top ? 11'sd15 : 11'sd14);
	end

	// Valid bits for stage 3 and the output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s3  <= in_valid;
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3   <= r_d;
			neg_s3 <= neg;
			end_s3 <= end_in;
			if (cls != CLS_NORMAL) begin
				cls_s3 <= cls;
				k_s3   <= 6'd1;
			end else if (ex_d >= 0) begin
				cls_s3 <= CLS_SAT;
				k_s3   <= 6'd1;
			end else if (ex_d < -11'sd40) begin
				cls_s3 <= CLS_ZERO;
				k_s3   <= 6'd1;
			end else begin
				cls_s3 <= CLS_NORMAL;
				k_s3   <= 6'(-ex_d);
			end
		end
	end

	// Round half away, cap, saturate, apply sign
	always_comb begin
		sum  = {41'd0, r_s3} + (66'd1 << (k_s3 - 6'd1));
		wide = sum >> k_s3;
		case (cls_s3)
			CLS_ZERO: cap = 17'd0;
			CLS_SAT:  cap = MagSat;
			default:  cap = (wide > 66'(MagSat)) ? MagSat : wide[16:0];
		endcase
		if (neg_s3) begin
			mag = (cap > MagMaxNeg) ? MagMaxNeg : cap;
		end else begin
			mag = (cap > MagMaxPos) ? MagMaxPos : cap;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item.pcm_sample     <= neg_s3 ? -$signed(mag[15:0]) : $signed(mag[15:0]);
			out_item.buffer_end_out <= end_s3;
		end
	end
endmodule

>>> test/float32_to_pcm16_saturating_test.sv
// Self-checking test of the float32 to 16-bit PCM converter.
// Depends on f2p_pkg, f2p_if and the float32_to_pcm16_saturating top level.
module float32_to_pcm16_saturating_test;
	timeunit 1ns;
	timeprecision 1ps;
	import f2p_pkg::*;

	localparam int unsigned RandomBeats = 700;
	localparam int unsigned StallLimit = 5000;
	localparam int unsigned DrainCycles = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	f2p_if #(.W($bits(f2p_in_t))) in_ch ();
	f2p_if #(.W($bits(f2p_out_t))) out_ch ();

	float32_to_pcm16_saturating dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	f2p_in_t pending_samples[$];
	f2p_out_t expected_pcm[$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	bit in_taken = 1'b0;
	bit hold_for_drain = 1'b0;
	bit send_steady = 1'b0;
	bit take_steady = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Magnitude of round_half_away(x * 32767) with the product first rounded
	// to 24 bits, capped at 65535.
	function automatic logic [16:0] scaled_mag(logic [7:0] e, logic [22:0] f);
		logic [47:0] prod;
		logic [47:0] low;
		logic [47:0] half;
		logic [47:0] r;
		logic [47:0] m;
		int len;
		int sh;
		int ex;
		int k;
		prod = {24'd0, 1'b1, f} * 48'd32767;
		len = 0;
		for (int i = 0; i < 48; i++)
			if (prod[i])
				len = i + 1;
		sh = 0;
		r = prod;
		if (len > 24) begin
			sh = len - 24;
			low = prod & ((48'd1 << sh) - 48'd1);
			half = 48'd1 << (sh - 1);
			r = prod >> sh;
			if (low > half || (low == half && r[0]))
				r = r + 48'd1;
		end
		ex = int'(e) - 150 + sh;
		if (ex >= 0)
			return MagSat;
		k = -ex;
		if (k > 40)
			return 17'd0;
		m = (r + (48'd1 << (k - 1))) >> k;
		if (m > 48'd65535)
			m = 48'd65535;
		return m[16:0];
	endfunction

	// Convert one sample to its saturated PCM value.
	function automatic f2p_out_t convert_sample(f2p_in_t s);
		f2p_out_t o;
		logic [7:0] e;
		logic [22:0] f;
		logic [16:0] mag;
		e = s.float_sample[30:23];
		f = s.float_sample[22:0];
		// NaN gives zero, infinity saturates
		if (e == ExpSpecial)
			mag = (f != 23'd0) ? 17'd0 : MagSat;
		else if (e == 8'd0)
			mag = 17'd0;
		else
			mag = scaled_mag(e, f);
		if (s.float_sample[31]) begin
			if (mag > MagMaxNeg)
				mag = MagMaxNeg;
			o.pcm_sample = 16'(-mag);
		end else begin
			if (mag > MagMaxPos)
				mag = MagMaxPos;
			o.pcm_sample = mag[15:0];
		end
		o.buffer_end_out = s.buffer_end;
		return o;
	endfunction

	function automatic void queue_sample(logic [31:0] bits, logic last);
		f2p_in_t s;
		s.float_sample = bits;
		s.buffer_end = last;
		pending_samples.push_back(s);
	endfunction

	// Drive input beats at the falling edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
		end else if (!in_ch.valid || in_taken) begin
			if (pending_samples.size() != 0 && !hold_for_drain &&
					(send_steady || $urandom_range(99) >= 35)) begin
				in_ch.valid <= 1'b1;
				in_ch.data <= pending_samples.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
		out_ch.ready <= !arst_n ? 1'b0 : (take_steady || $urandom_range(99) >= 35);
	end

	// Record expectations and check results at the rising edge.
	always @(posedge clk) begin
		f2p_out_t got;
		f2p_out_t want;
		in_taken <= arst_n && in_ch.valid && in_ch.ready;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				expected_pcm.push_back(convert_sample(in_ch.data));
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (expected_pcm.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected beat: pcm %0d end %0b",
							got.pcm_sample, got.buffer_end_out);
				end else begin
					want = expected_pcm.pop_front();
					if (got.pcm_sample !== want.pcm_sample ||
							got.buffer_end_out !== want.buffer_end_out) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: pcm exp %0d got %0d, end exp %0b got %0b",
								want.pcm_sample, got.pcm_sample,
								want.buffer_end_out, got.buffer_end_out);
					end
				end
			end
		end
	end

	// Watch for a stalled pipeline.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [31:0] bits;
		logic [7:0] e;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n = 1'b1;

		// Directed extremes and special values.
		queue_sample(32'h0000_0000, 1'b0);
		queue_sample(32'h8000_0000, 1'b1);
		queue_sample(32'h0000_0001, 1'b0);
		queue_sample(32'h807F_FFFF, 1'b0);
		queue_sample(32'h7F80_0000, 1'b1);
		queue_sample(32'hFF80_0000, 1'b0);
		queue_sample(32'h7FC0_0000, 1'b0);
		queue_sample(32'hFFFF_FFFF, 1'b1);
		queue_sample(32'h7F80_0001, 1'b0);
		queue_sample(32'h3F80_0000, 1'b0);
		queue_sample(32'hBF80_0000, 1'b0);
		queue_sample(32'h3F80_0100, 1'b0);
		queue_sample(32'h3F80_0200, 1'b0);
		queue_sample(32'hBF80_0100, 1'b0);
		queue_sample(32'hBF80_0200, 1'b1);
		queue_sample(32'h3F00_0000, 1'b0);
		queue_sample(32'h3800_0000, 1'b0);
		queue_sample(32'h3800_0100, 1'b0);
		queue_sample(32'hB800_0100, 1'b0);
		queue_sample(32'h7F7F_FFFF, 1'b0);
		queue_sample(32'hFF7F_FFFF, 1'b1);
		queue_sample(32'h0080_0000, 1'b0);
		queue_sample(32'h3F7F_FFFF, 1'b0);

		// Pause until the directed beats have all come back.
		wait (pending_samples.size() == 0);
		hold_for_drain = 1'b1;
		wait (!in_ch.valid);
		wait (expected_pcm.size() == 0);
		@(negedge clk);
		hold_for_drain = 1'b0;

		// Random beats: mostly audio range, some of any bit pattern.
		for (int i = 0; i < RandomBeats; i++) begin
			bits = $urandom;
			if ($urandom_range(99) < 70) begin
				e = 8'($urandom_range(8'h8E, 8'h60));
				if ($urandom_range(9) < 3)
					e = 8'h7E + 8'($urandom_range(1));
				bits[30:23] = e;
			end
			queue_sample(bits, 1'($urandom_range(1)));
			if (i == 300) begin
				wait (pending_samples.size() == 0);
				send_steady = 1'b1;
				take_steady = 1'b1;
			end
			if (i == 450) begin
				wait (pending_samples.size() == 0);
				send_steady = 1'b0;
				take_steady = 1'b0;
			end
		end

		wait (pending_samples.size() == 0);
		wait (!in_ch.valid);
		wait (expected_pcm.size() == 0);
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0 && expected_pcm.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
